// ===== rtl/mnsp_pkg.sv =====
// ----------------------------------------------------------------------------
// mnsp_pkg
// Types, constants and helper functions for the media name size parser.
// ----------------------------------------------------------------------------
package mnsp_pkg;

  localparam int WHOLE_W    = 20;
  localparam int FRAC_W     = 10;
  localparam int CNT_W      = 2;
  localparam int COEF_W     = 15;
  localparam int PROD_W     = FRAC_W + COEF_W;
  localparam int X_W        = 18;
  localparam int RECIP_W    = 19;
  localparam int QP_W       = X_W + RECIP_W;
  localparam int RECIP_SHIFT = 25;
  localparam int Q_W        = QP_W - RECIP_SHIFT;
  localparam int DIM_W      = 32;
  localparam int MULW_W     = 12;
  localparam int LEN_W      = 3;
  localparam int QUEUE_AW   = 2;
  localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

  localparam logic [WHOLE_W-1:0] WHOLE_LIMIT = WHOLE_W'(100000);
  localparam logic [LEN_W-1:0]   LEN_MAX     = LEN_W'(6);
  localparam logic [LEN_W-1:0]   LEN_ENOUGH  = LEN_W'(5);
  localparam logic [CNT_W-1:0]   CNT_MAX     = CNT_W'(3);

  // (x * RECIP) >> RECIP_SHIFT equals x / 100 for every x below 2**X_W
  localparam logic [RECIP_W-1:0] RECIP       = RECIP_W'(335545);
  localparam logic [PROD_W-1:0]  ROUND_BIAS  = PROD_W'(50);
  localparam logic [MULW_W-1:0]  MULW_MM     = MULW_W'(100);
  localparam logic [MULW_W-1:0]  MULW_IN     = MULW_W'(2540);

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_X          = 8'h78;
  localparam logic [7:0] CH_POINT      = 8'h2E;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_M          = 8'h6D;
  localparam logic [7:0] CH_I          = 8'h69;
  localparam logic [7:0] CH_N          = 8'h6E;

  typedef struct packed {
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
    logic               point;
    logic               digit;
    logic               bad;
    logic [CNT_W-1:0]   cnt;
  } num_t;

  // one finished name handed from front to back
  typedef struct packed {
    logic ok;
    logic inch;
    num_t first;
    num_t second;
  } job_t;

  function automatic num_t feed_number(num_t n, logic [7:0] c);
    num_t       r;
    logic [3:0] d;
    r = n;
    d = c[3:0];
    if (!n.bad) begin
      if (c == CH_POINT && !n.point) begin
        r.point = 1'b1;
      end else if (!(c inside {[CH_ZERO:CH_NINE]})) begin
        r.bad = 1'b1;
      end else begin
        r.digit = 1'b1;
        if (!n.point) begin
          if (n.whole > WHOLE_LIMIT) begin
            r.bad = 1'b1;
          end else begin
            r.whole = n.whole * WHOLE_W'(10) + WHOLE_W'(d);
          end
        end else if (n.cnt < CNT_MAX) begin
          r.frac = n.frac * FRAC_W'(10) + FRAC_W'(d);
          r.cnt  = n.cnt + CNT_W'(1);
        end
      end
    end
    return r;
  endfunction

  // fraction to thousandths, times the unit factor over ten
  function automatic logic [COEF_W-1:0] frac_coef(logic inch, logic [CNT_W-1:0] cnt);
    logic [COEF_W-1:0] r;
    case (cnt)
      2'd0:    r = inch ? COEF_W'(25400) : COEF_W'(1000);
      2'd1:    r = inch ? COEF_W'(25400) : COEF_W'(1000);
      2'd2:    r = inch ? COEF_W'(2540)  : COEF_W'(100);
      2'd3:    r = inch ? COEF_W'(254)   : COEF_W'(10);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/mnsp_front.sv =====
// ----------------------------------------------------------------------------
// mnsp_front
// Takes characters, runs the two-byte hold and the number parsers, and pushes
// one job per name on the last character.
// ----------------------------------------------------------------------------
module mnsp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_character,
  input  logic               in_final_char,
  input  logic               q_full,
  output logic               q_push,
  output mnsp_pkg::job_t     q_data
);
  import mnsp_pkg::*;

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       held0_r, held0_nxt;
  logic [7:0]       held1_r, held1_nxt;
  logic             second_r, second_nxt;
  num_t             num1_r, num1_nxt;
  num_t             num2_r, num2_nxt;
  logic             accept;
  logic             suffix_mm, suffix_in;
  logic             fin1_ok, fin2_ok;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && in_final_char;

  always_comb begin
    second_nxt = second_r;
    num1_nxt   = num1_r;
    num2_nxt   = num2_r;
    if (len_r >= LEN_W'(2)) begin
      if (held0_r == CH_UNDERSCORE) begin
        second_nxt = 1'b0;
        num1_nxt   = '0;
        num2_nxt   = '0;
      end else if (!second_r && held0_r == CH_X) begin
        second_nxt = 1'b1;
      end else if (!second_r) begin
        num1_nxt = feed_number(num1_r, held0_r);
      end else begin
        num2_nxt = feed_number(num2_r, held0_r);
      end
    end
    held0_nxt = held1_r;
    held1_nxt = in_character;
    len_nxt   = (len_r < LEN_MAX) ? len_r + LEN_W'(1) : len_r;

    // the suffix is the last two characters, never fed to the parsers
    suffix_mm = held1_r == CH_M && in_character == CH_M;
    suffix_in = held1_r == CH_I && in_character == CH_N;
    fin1_ok   = num1_nxt.digit && !num1_nxt.bad;
    fin2_ok   = num2_nxt.digit && !num2_nxt.bad;

    q_data.ok     = (len_r >= LEN_ENOUGH) && (suffix_mm || suffix_in) && second_nxt
                    && fin1_ok && fin2_ok;
    q_data.inch   = suffix_in;
    q_data.first  = num1_nxt;
    q_data.second = num2_nxt;

    if (in_final_char) begin
      len_nxt    = '0;
      held0_nxt  = '0;
      held1_nxt  = '0;
      second_nxt = 1'b0;
      num1_nxt   = '0;
      num2_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      held0_r  <= '0;
      held1_r  <= '0;
      second_r <= 1'b0;
      num1_r   <= '0;
      num2_r   <= '0;
    end else if (accept) begin
      len_r    <= len_nxt;
      held0_r  <= held0_nxt;
      held1_r  <= held1_nxt;
      second_r <= second_nxt;
      num1_r   <= num1_nxt;
      num2_r   <= num2_nxt;
    end
  end

endmodule

// ===== rtl/mnsp_queue.sv =====
// ----------------------------------------------------------------------------
// mnsp_queue
// Small job queue between the parser front and the scaling back end.
// ----------------------------------------------------------------------------
module mnsp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mnsp_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output mnsp_pkg::job_t pop_data,
  output logic           empty
);
  import mnsp_pkg::*;

  job_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign full     = count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign empty    = count_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QUEUE_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QUEUE_AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QUEUE_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/mnsp_back.sv =====
// ----------------------------------------------------------------------------
// mnsp_back
// Three-stage scaling pipe: unit multiply, divide by 100 by reciprocal,
// final add and zero check into the output register.
// ----------------------------------------------------------------------------
module mnsp_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  mnsp_pkg::job_t             q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_valid_res,
  output logic [mnsp_pkg::DIM_W-1:0] out_width_hmm,
  output logic [mnsp_pkg::DIM_W-1:0] out_height_hmm
);
  import mnsp_pkg::*;

  logic               adv;
  logic [MULW_W-1:0]  mulw;
  logic [PROD_W-1:0]  xf1, xf2;
  logic [QP_W-1:0]    qp1, qp2;
  logic [DIM_W-1:0]   sum1, sum2;

  logic               a_vld_r, a_ok_r;
  logic [DIM_W-1:0]   a_wp1_r, a_wp2_r;
  logic [X_W-1:0]     a_x1_r, a_x2_r;
  logic               b_vld_r, b_ok_r;
  logic [DIM_W-1:0]   b_wp1_r, b_wp2_r;
  logic [Q_W-1:0]     b_q1_r, b_q2_r;
  logic               o_vld_r, o_res_r;
  logic [DIM_W-1:0]   o_w_r, o_h_r;

  // the whole pipe moves unless a result sits stalled at the output
  assign adv   = !o_vld_r || !out_stall;
  assign q_pop = adv && !q_empty;

  always_comb begin
    mulw = q_data.inch ? MULW_IN : MULW_MM;
    xf1  = PROD_W'(q_data.first.frac) * PROD_W'(frac_coef(q_data.inch, q_data.first.cnt))
           + ROUND_BIAS;
    xf2  = PROD_W'(q_data.second.frac) * PROD_W'(frac_coef(q_data.inch, q_data.second.cnt))
           + ROUND_BIAS;
    qp1  = QP_W'(a_x1_r) * QP_W'(RECIP);
    qp2  = QP_W'(a_x2_r) * QP_W'(RECIP);
    sum1 = b_wp1_r + DIM_W'(b_q1_r);
    sum2 = b_wp2_r + DIM_W'(b_q2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= !q_empty;
      b_vld_r <= a_vld_r;
      o_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ok_r  <= q_data.ok;
      a_wp1_r <= DIM_W'(q_data.first.whole) * DIM_W'(mulw);
      a_wp2_r <= DIM_W'(q_data.second.whole) * DIM_W'(mulw);
      a_x1_r  <= xf1[X_W-1:0];
      a_x2_r  <= xf2[X_W-1:0];

      b_ok_r  <= a_ok_r;
      b_wp1_r <= a_wp1_r;
      b_wp2_r <= a_wp2_r;
      b_q1_r  <= qp1[RECIP_SHIFT +: Q_W];
      b_q2_r  <= qp2[RECIP_SHIFT +: Q_W];

      if (b_ok_r && sum1 != '0 && sum2 != '0) begin
        o_res_r <= 1'b1;
        o_w_r   <= sum1;
        o_h_r   <= sum2;
      end else begin
        o_res_r <= 1'b0;
        o_w_r   <= '0;
        o_h_r   <= '0;
      end
    end
  end

  assign out_valid      = o_vld_r;
  assign out_valid_res  = o_res_r;
  assign out_width_hmm  = o_w_r;
  assign out_height_hmm = o_h_r;

endmodule

// ===== rtl/media_name_size_parser_top.sv =====
// ----------------------------------------------------------------------------
// media_name_size_parser_top
// Parses a media size name one character per item and reports its width and
// height in hundredths of a millimetre.
//
//   channel  dir  handshake          payload
//   in       in   in_valid/in_stall  in_character[7:0], in_final_char
//   out      out  out_valid/out_stall out_valid_res, out_width_hmm[31:0],
//                                    out_height_hmm[31:0]
//
// One character is taken every cycle unless the queue is full; the parser
// front does one digit step per character. A result leaves through a
// four-entry job queue and a three-stage multiply pipe.
// Reset is synchronous and clears the parser state, queue and pipe valids.
// A stalled output holds the pipe; the input stalls only when the queue is full.
// ----------------------------------------------------------------------------
module media_name_size_parser_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_character,
  input  logic                       in_final_char,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_valid_res,
  output logic [mnsp_pkg::DIM_W-1:0] out_width_hmm,
  output logic [mnsp_pkg::DIM_W-1:0] out_height_hmm
);
  import mnsp_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  job_t push_job, pop_job;

  mnsp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_character  (in_character),
    .in_final_char (in_final_char),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (push_job)
  );

  mnsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_job),
    .empty     (q_empty)
  );

  mnsp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (pop_job),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_valid_res  (out_valid_res),
    .out_width_hmm  (out_width_hmm),
    .out_height_hmm (out_height_hmm)
  );

endmodule
